// File: src/sses_pkg.sv
// Shared types and constants for the sorted sparse element store
`timescale 1ns / 1ps
package sses_pkg;
  localparam int CAPACITY = 1024;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;

  localparam logic CMD_SET = 1'b0;
  localparam logic CMD_GET = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_NOT_LOCAL = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [2:0] REG_ROWS = 3'd0;
  localparam logic [2:0] REG_COLS = 3'd1;
  localparam logic [2:0] REG_FIRST = 3'd2;
  localparam logic [2:0] REG_END = 3'd3;
  localparam logic [2:0] REG_CPLX = 3'd4;

  typedef struct packed {
    logic        command;
    logic [15:0] row;
    logic [15:0] column;
    logic [63:0] value_re;
    logic [63:0] value_im;
  } in_item_t;

  typedef struct packed {
    logic [63:0] read_re;
    logic [63:0] read_im;
    logic        found;
    logic [1:0]  status;
    logic [10:0] entry_total;
  } out_item_t;

  // one memory row: key and both value words
  typedef struct packed {
    logic [31:0] key;
    logic [63:0] re;
    logic [63:0] im;
  } entry_t;

  typedef struct packed {
    logic        we;
    logic [AW-1:0] waddr;
    entry_t      wdata;
    logic        re;
    logic [AW-1:0] raddr;
  } mem_req_t;
endpackage

// File: src/sses_if.sv
// Valid/ready channel interfaces for the store
`timescale 1ns / 1ps
interface sses_in_if;
  import sses_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sses_out_if;
  import sses_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/sorted_sparse_element_store.sv
// Top level of the sorted sparse element store
//  channel | dir | payload
//  in_     | in  | command, row, column, value_re, value_im
//  out_    | out | read_re, read_im, found, status, entry_total
//  cfg_    | in  | write enable, index, 16-bit data
// One item at a time. The result follows the input transfer after p binary
// search probes (each a read, then a compare, on the single read port; at most
// floor(log2(count))+1, so 11 at a full table, none when empty). An insert
// also moves up the m entries above the slot, one read and one write each.
// Reset is synchronous and clears the entry count; memory holds no reset.
// A waiting result holds until taken; the next input transfer can come in
// the cycle after the result transfer.
`timescale 1ns / 1ps
module sorted_sparse_element_store (
  input  logic        clk,
  input  logic        rst_n,
  sses_in_if.sink     in_ch,
  sses_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sses_pkg::*;

  logic [15:0] num_rows_r, num_columns_r, first_r, end_r;
  logic        cplx_r;
  mem_req_t    req;
  entry_t      rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r    <= 16'd1;
      num_columns_r <= 16'd1;
      first_r       <= '0;
      end_r         <= '0;
      cplx_r        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS:  num_rows_r    <= cfg_data;
        REG_COLS:  num_columns_r <= cfg_data;
        REG_FIRST: first_r       <= cfg_data;
        REG_END:   end_r         <= cfg_data;
        REG_CPLX:  cplx_r        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sses_ctrl u_ctrl (
    .clk, .rst_n,
    .num_rows(num_rows_r), .num_columns(num_columns_r),
    .local_first_row(first_r), .local_end_row(end_r), .is_complex(cplx_r),
    .in_ch, .out_ch, .req, .rdata
  );

  sses_mem u_mem (.clk, .req, .rdata);
endmodule

// File: src/sses_mem.sv
// Entry memory: one write port, one registered read port
`timescale 1ns / 1ps
module sses_mem (
  input  logic              clk,
  input  sses_pkg::mem_req_t req,
  output sses_pkg::entry_t   rdata
);
  import sses_pkg::*;
  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end
endmodule

// File: src/sses_ctrl.sv
// Sequencer: checks, binary search, shift-insert or overwrite, result
`timescale 1ns / 1ps
module sses_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [15:0]          num_rows,
  input  logic [15:0]          num_columns,
  input  logic [15:0]          local_first_row,
  input  logic [15:0]          local_end_row,
  input  logic                 is_complex,
  sses_in_if.sink              in_ch,
  sses_out_if.source           out_ch,
  output sses_pkg::mem_req_t   req,
  input  sses_pkg::entry_t     rdata
);
  import sses_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_KEY   = 3'd1;
  localparam logic [2:0] S_SRCH  = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_SHWR  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CW-1:0] sp_r, sp_nxt;        // shift pointer
  logic          rd_pend_r, rd_pend_nxt;
  in_item_t      item_r;
  logic [31:0]   key_r;
  logic          ovalid_r, ovalid_nxt;
  out_item_t     odata_r, odata_nxt;
  logic [CW-1:0] mid;
  logic          hit;
  logic [63:0]   im_val;

  assign in_ch.ready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = odata_r;
  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign hit = (lo_r < count_r) && (rdata.key == key_r);
  assign im_val = is_complex ? item_r.value_im : 64'd0;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    sp_nxt      = sp_r;
    rd_pend_nxt = 1'b0;
    ovalid_nxt  = ovalid_r;
    odata_nxt   = odata_r;
    req         = '0;
    if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          state_nxt = S_KEY;
        end
      end
      S_KEY: begin
        odata_nxt = '0;
        odata_nxt.entry_total = count_r;
        lo_nxt = '0;
        hi_nxt = count_r;
        if (item_r.row >= num_rows || item_r.column >= num_columns) begin
          odata_nxt.status = ST_RANGE;
          state_nxt = S_DONE;
        end else if (item_r.row < local_first_row || item_r.row >= local_end_row) begin
          odata_nxt.status = ST_NOT_LOCAL;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        // each probe issues a read, then compares the returned key
        if (rd_pend_r) begin
          if (rdata.key < key_r) lo_nxt = mid + 1'b1;
          else hi_nxt = mid;
        end else if (lo_r < hi_r) begin
          req.re = 1'b1;
          req.raddr = mid[AW-1:0];
          rd_pend_nxt = 1'b1;
        end else begin
          req.re = 1'b1;
          req.raddr = lo_r[AW-1:0];
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        odata_nxt.found = hit;
        if (hit) begin
          if (item_r.command == CMD_GET) begin
            odata_nxt.read_re = rdata.re;
            odata_nxt.read_im = is_complex ? rdata.im : 64'd0;
          end else begin
            req.we = 1'b1;
            req.waddr = lo_r[AW-1:0];
            req.wdata = '{key: key_r, re: item_r.value_re, im: im_val};
          end
          state_nxt = S_DONE;
        end else if (item_r.command == CMD_GET) begin
          state_nxt = S_DONE;
        end else if (count_r == CW'(CAPACITY)) begin
          odata_nxt.status = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          sp_nxt = count_r;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sp_r == lo_r) begin
          req.we = 1'b1;
          req.waddr = lo_r[AW-1:0];
          req.wdata = '{key: key_r, re: item_r.value_re, im: im_val};
          count_nxt = count_r + 1'b1;
          odata_nxt.entry_total = count_r + 1'b1;
          state_nxt = S_DONE;
        end else begin
          req.re = 1'b1;
          req.raddr = sp_r[AW-1:0] - 1'b1;
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        req.we = 1'b1;
        req.waddr = sp_r[AW-1:0];
        req.wdata = rdata;
        sp_nxt = sp_r - 1'b1;
        state_nxt = S_SHIFT;
      end
      S_DONE: begin
        ovalid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      ovalid_r  <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      ovalid_r  <= ovalid_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    sp_r    <= sp_nxt;
    odata_r <= odata_nxt;
    if (in_ch.valid && in_ch.ready) begin
      item_r <= in_ch.data;
    end
    if (state_r == S_KEY) begin
      key_r <= 32'(item_r.row) * 32'(num_columns) + 32'(item_r.column);
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY)) else $error("entry count over capacity");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |-> count_r == $past(count_r) + 1'b1)
    else $error("entry count moved by other than one");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_we_re: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SRCH |-> !req.we) else $error("write during search");
endmodule
